// ----- design/imm_pkg.sv -----
package imm_pkg;

    // Fixed field widths
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ELEM_IN_W = 16;
    localparam int PROD_W    = 35;
    localparam int IDX_W     = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A = 2'd0,
        REG_COLS_A = 2'd1,
        REG_ROWS_B = 2'd2,
        REG_COLS_B = 2'd3
    } t_reg_idx;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;      // store request element in A
        logic             wr_b;      // store request element in B
        logic             rd_en;     // read one A/B pair into the MAC pipe
        logic             rd_first;  // first term of a dot product
        logic             rd_last;   // last term of a dot product
        logic             put;       // move finished sum to the output
        logic             put_err;   // emit a dimension error result
        logic             put_last;  // final element of the product matrix
        logic [IDX_W-1:0] put_row;
        logic [IDX_W-1:0] put_col;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic acc_done;  // accumulator holds a finished dot product
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

// ----- design/imm_ctrl.sv -----
module imm_ctrl import imm_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_index,
    input  logic [CFG_W-1:0]                       i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  t_status                                i_status,
    output t_cmd                                   o_cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     o_wr_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     o_rd_a_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     o_rd_b_addr
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int CW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int IW = $clog2(MAX_DIM);

    typedef enum logic [1:0] {
        S_LOAD,
        S_MAC,
        S_PUT
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic             r_in_b;
    logic [AW-1:0]    r_ld_addr;
    logic [IW-1:0]    r_r, r_c, r_k;
    logic [AW-1:0]    r_a_base, r_a_addr, r_b_addr;

    logic [DW-1:0]    ra, ca, rb, cb;
    logic [CW-1:0]    total_a, total_b;
    logic [IW-1:0]    ra_m1, ca_m1, cb_m1;
    logic             mismatch;
    logic             accept;
    logic             ld_end_a, ld_end_b;
    logic             k_last, c_last, r_last;

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DW-1:0] d;
        if (v == '0) begin
            d = DW'(1);
        end else if (int'(v) > MAX_DIM) begin
            d = DW'(MAX_DIM);
        end else begin
            d = DW'(v);
        end
        return d;
    endfunction

    // Effective dimensions and element totals
    always_comb begin
        ra       = eff_dim(r_rows_a);
        ca       = eff_dim(r_cols_a);
        rb       = eff_dim(r_rows_b);
        cb       = eff_dim(r_cols_b);
        total_a  = CW'(ra) * CW'(ca);
        total_b  = CW'(rb) * CW'(cb);
        ra_m1    = IW'(ra - DW'(1));
        ca_m1    = IW'(ca - DW'(1));
        cb_m1    = IW'(cb - DW'(1));
        mismatch = (ca != rb);
    end

    // Input handshake: error requests need a free output register
    assign o_in_stall = (r_state != S_LOAD) || (mismatch && !i_status.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign ld_end_a = (CW'(r_ld_addr) == total_a - CW'(1));
    assign ld_end_b = (CW'(r_ld_addr) == total_b - CW'(1));
    assign k_last   = (r_k == ca_m1);
    assign c_last   = (r_c == cb_m1);
    assign r_last   = (r_r == ra_m1);

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_a     = accept && !mismatch && !r_in_b;
        o_cmd.wr_b     = accept && !mismatch && r_in_b;
        o_cmd.put_err  = accept && mismatch;
        o_cmd.rd_en    = (r_state == S_MAC);
        o_cmd.rd_first = (r_k == '0);
        o_cmd.rd_last  = k_last;
        o_cmd.put      = (r_state == S_PUT) && i_status.acc_done && i_status.out_free;
        o_cmd.put_last = r_last && c_last;
        o_cmd.put_row  = IDX_W'(r_r);
        o_cmd.put_col  = IDX_W'(r_c);
        o_wr_addr      = r_ld_addr;
        o_rd_a_addr    = r_a_addr;
        o_rd_b_addr    = r_b_addr;
    end

    // State, configuration and sequencing counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_rows_a  <= CFG_W'(1);
            r_cols_a  <= CFG_W'(1);
            r_rows_b  <= CFG_W'(1);
            r_cols_b  <= CFG_W'(1);
            r_in_b    <= 1'b0;
            r_ld_addr <= '0;
            r_r       <= '0;
            r_c       <= '0;
            r_k       <= '0;
            r_a_base  <= '0;
            r_a_addr  <= '0;
            r_b_addr  <= '0;
        end else if (i_cfg_we) begin
            // any register write restarts loading
            unique case (i_cfg_index)
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_ROWS_B: r_rows_b <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
                default:    r_rows_a <= r_rows_a;
            endcase
            r_in_b    <= 1'b0;
            r_ld_addr <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept && !mismatch) begin
                        if (!r_in_b) begin
                            if (ld_end_a) begin
                                r_in_b    <= 1'b1;
                                r_ld_addr <= '0;
                            end else begin
                                r_ld_addr <= r_ld_addr + AW'(1);
                            end
                        end else if (ld_end_b) begin
                            // last element of B: start the product
                            r_in_b    <= 1'b0;
                            r_ld_addr <= '0;
                            r_r       <= '0;
                            r_c       <= '0;
                            r_k       <= '0;
                            r_a_base  <= '0;
                            r_a_addr  <= '0;
                            r_b_addr  <= '0;
                            r_state   <= S_MAC;
                        end else begin
                            r_ld_addr <= r_ld_addr + AW'(1);
                        end
                    end
                end
                S_MAC: begin
                    // walk row r of A and column c of B
                    if (k_last) begin
                        r_state <= S_PUT;
                    end else begin
                        r_k      <= r_k + IW'(1);
                        r_a_addr <= r_a_addr + AW'(1);
                        r_b_addr <= r_b_addr + AW'(cb);
                    end
                end
                S_PUT: begin
                    if (o_cmd.put) begin
                        r_k <= '0;
                        if (r_last && c_last) begin
                            r_state <= S_LOAD;
                        end else if (c_last) begin
                            r_c      <= '0;
                            r_r      <= r_r + IW'(1);
                            r_a_base <= r_a_base + AW'(ca);
                            r_a_addr <= r_a_base + AW'(ca);
                            r_b_addr <= '0;
                            r_state  <= S_MAC;
                        end else begin
                            r_c      <= r_c + IW'(1);
                            r_a_addr <= r_a_base;
                            r_b_addr <= AW'(r_c) + AW'(1);
                            r_state  <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

// ----- design/imm_dp.sv -----
module imm_dp import imm_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_cmd                                   i_cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     i_wr_addr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     i_rd_a_addr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     i_rd_b_addr,
    input  logic [ELEM_BITS-1:0]                   i_element,
    input  logic                                   i_out_stall,
    output t_status                                o_status,
    output logic                                   o_out_valid,
    output logic signed [PROD_W-1:0]               o_product,
    output logic [IDX_W-1:0]                       o_row_index,
    output logic [IDX_W-1:0]                       o_col_index,
    output logic                                   o_last,
    output logic                                   o_dims_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = 2 * ELEM_BITS;
    localparam int XW    = (MW > PROD_W) ? MW : PROD_W;

    logic [ELEM_BITS-1:0]        mem_a [DEPTH];
    logic [ELEM_BITS-1:0]        mem_b [DEPTH];

    logic signed [ELEM_BITS-1:0] r_a_q, r_b_q;
    logic                        r_s1_v, r_s1_first, r_s1_last;
    logic signed [PROD_W-1:0]    r_prod;
    logic                        r_s2_v, r_s2_first, r_s2_last;
    logic signed [PROD_W-1:0]    r_acc;
    logic                        r_acc_done;
    logic                        r_out_valid;

    logic signed [MW-1:0]        mul;
    logic signed [XW-1:0]        mul_x;

    // Element stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[i_wr_addr] <= i_element;
        end
        if (i_cmd.wr_b) begin
            mem_b[i_wr_addr] <= i_element;
        end
        r_a_q <= mem_a[i_rd_a_addr];
        r_b_q <= mem_b[i_rd_b_addr];
    end

    // Multiply, sign extended or wrapped to the product width
    assign mul   = r_a_q * r_b_q;
    assign mul_x = XW'(mul);

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.rd_first;
        r_s1_last  <= i_cmd.rd_last;
        r_prod     <= mul_x[PROD_W-1:0];
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s2_v) begin
            r_acc <= r_s2_first ? r_prod : r_acc + r_prod;
        end
    end

    // Pipe valid bits and finished-sum flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.rd_en;
            r_s2_v <= r_s1_v;
            if (i_cmd.put) begin
                r_acc_done <= 1'b0;
            end else if (r_s2_v && r_s2_last) begin
                r_acc_done <= 1'b1;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            priority if (i_cmd.put || i_cmd.put_err) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.put) begin
            o_product    <= r_acc;
            o_row_index  <= i_cmd.put_row;
            o_col_index  <= i_cmd.put_col;
            o_last       <= i_cmd.put_last;
            o_dims_error <= 1'b0;
        end else if (i_cmd.put_err) begin
            o_product    <= '0;
            o_row_index  <= '0;
            o_col_index  <= '0;
            o_last       <= 1'b0;
            o_dims_error <= 1'b1;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.acc_done = r_acc_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

// ----- design/integer_matrix_multiply.sv -----
// Loading: one element request per cycle, no result until the last element of B.
// After the last element of B, each product element reads one A/B pair from the stores per
// term through the read/multiply/add pipe and waits for a free output register; input
// stays stalled until the last product element has moved to the output.
// A dimension error request returns one result; it is accepted once the output frees.
// Synchronous active-low reset clears control, sets all dimensions to 1; stores keep data.
module integer_matrix_multiply import imm_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [ELEM_IN_W-1:0]     i_element,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [PROD_W-1:0] o_product,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic                     o_last,
    output logic                     o_dims_error
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    t_cmd                 cmd;
    t_status              status;
    logic [AW-1:0]        wr_addr, rd_a_addr, rd_b_addr;
    logic [ELEM_BITS-1:0] element;

    // Low ELEM_BITS bits of the request element
    assign element = ELEM_BITS'(i_element);

    imm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_a_addr (rd_a_addr),
        .o_rd_b_addr (rd_b_addr)
    );

    imm_dp #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wr_addr    (wr_addr),
        .i_rd_a_addr  (rd_a_addr),
        .i_rd_b_addr  (rd_b_addr),
        .i_element    (element),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_product    (o_product),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_last       (o_last),
        .o_dims_error (o_dims_error)
    );

endmodule

// ----- design/imm_checker.sv -----
module imm_checker import imm_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [PROD_W-1:0] o_product,
    input logic [IDX_W-1:0]         o_row_index,
    input logic [IDX_W-1:0]         o_col_index,
    input logic                     o_last,
    input logic                     o_dims_error
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // Error results carry an all-zero payload
    a_err_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dims_error) |->
            (o_product == '0) && (o_row_index == '0) && (o_col_index == '0) && !o_last)
        else $error("dimension error result with nonzero payload");

    // Final product element is never an error result
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> !o_dims_error)
        else $error("last mark on an error result");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_product) && $stable(o_row_index)
            && $stable(o_col_index) && $stable(o_last) && $stable(o_dims_error))
        else $error("stalled result changed");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_product    (o_product),
    .o_row_index  (o_row_index),
    .o_col_index  (o_col_index),
    .o_last       (o_last),
    .o_dims_error (o_dims_error)
);
